### rtl/cmtx_pkg.sv
// package for the cube map texel address unit
// types, widths, status and face codes shared by all rtl files
// no dependencies
`default_nettype none
package cmtx_pkg;
	localparam int DIR_W      = 16;
	localparam int UV_FRAC    = 16;
	localparam int DIV_W      = DIR_W + 1;
	localparam int REM_W      = DIV_W - 1;
	localparam int QUO_W      = UV_FRAC + 1;
	localparam int DIV_CELLS  = UV_FRAC;
	localparam int TEX_W      = 12;
	localparam int EXT_W      = 13;
	localparam int MAX_EXT    = 4096;
	localparam int ADDR_W     = 32;
	localparam int WN_W       = 16;
	localparam int WHN_W      = 28;
	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = 5;
	localparam int CREDIT_W   = FIFO_AW + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_CUBE  = 3'd1;
	localparam logic [2:0] ST_FACE_OOR  = 3'd2;
	localparam logic [2:0] ST_BAD_BYTES = 3'd3;
	localparam logic [2:0] ST_OOB       = 3'd4;
	localparam logic [2:0] ST_ZERO_DIR  = 3'd5;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_IS_CUBE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FACE_W     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACE_H     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYERS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_BYTES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_BYTES = 3'd6;

	typedef struct packed {
		logic [DIV_W-1:0] div;
		logic [REM_W-1:0] rem_u;
		logic [QUO_W-1:0] quo_u;
		logic [REM_W-1:0] rem_v;
		logic [QUO_W-1:0] quo_v;
	} cmtx_div_t;

	typedef struct packed {
		logic [2:0] face;
		logic       zero;
	} cmtx_side_t;

	typedef struct packed {
		logic              is_cube;
		logic [TEX_W-1:0]  w_m1;
		logic [TEX_W-1:0]  h_m1;
		logic [WN_W-1:0]   wn;
		logic [WHN_W-1:0]  whn;
		logic [2:0]        n;
		logic              bytes_ok;
		logic [7:0]        layers;
		logic [ADDR_W-1:0] base;
	} cmtx_cfg_t;

	typedef struct packed {
		logic [2:0]        face;
		logic [TEX_W-1:0]  tx;
		logic [TEX_W-1:0]  ty;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        status;
	} cmtx_res_t;
endpackage
`default_nettype wire

### rtl/cmtx_front.sv
// front end: input register, major axis and face pick, divider setup
// depends on cmtx_pkg
`default_nettype none
module cmtx_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           take,
	input  wire logic [cmtx_pkg::DIR_W-1:0]     dir_x,
	input  wire logic [cmtx_pkg::DIR_W-1:0]     dir_y,
	input  wire logic [cmtx_pkg::DIR_W-1:0]     dir_z,
	output logic                                next_valid,
	output cmtx_pkg::cmtx_div_t                 next_div,
	output cmtx_pkg::cmtx_side_t                next_side
);
	logic                         valid_s0, valid_s1, valid_s2;
	logic [cmtx_pkg::DIR_W-1:0]   x_s0, y_s0, z_s0;
	logic [cmtx_pkg::DIR_W:0]     xe, ye, ze, nx, ny, nz;
	logic [cmtx_pkg::REM_W-1:0]   ax, ay, az, major;
	logic [cmtx_pkg::DIR_W+1:0]   sc, tc, sum_u, sum_v;
	logic [2:0]                   face;
	logic                         sel_z, sel_y;
	logic [2:0]                   face_s1;
	logic                         zero_s1;
	logic [cmtx_pkg::REM_W-1:0]   major_s1;
	logic [cmtx_pkg::DIV_W-1:0]   nu_s1, nv_s1, div;
	logic                         q16_u, q16_v;
	cmtx_pkg::cmtx_div_t          div_s2;
	cmtx_pkg::cmtx_side_t         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s0 <= take;
			valid_s1 <= valid_s0;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s0 <= dir_x;
			y_s0 <= dir_y;
			z_s0 <= dir_z;
		end
	end

	// exact magnitudes, the most negative value included
	always_comb begin
		xe = {x_s0[cmtx_pkg::DIR_W-1], x_s0};
		ye = {y_s0[cmtx_pkg::DIR_W-1], y_s0};
		ze = {z_s0[cmtx_pkg::DIR_W-1], z_s0};
		nx = -xe;
		ny = -ye;
		nz = -ze;
		ax = x_s0[cmtx_pkg::DIR_W-1] ? nx[cmtx_pkg::REM_W-1:0] : x_s0;
		ay = y_s0[cmtx_pkg::DIR_W-1] ? ny[cmtx_pkg::REM_W-1:0] : y_s0;
		az = z_s0[cmtx_pkg::DIR_W-1] ? nz[cmtx_pkg::REM_W-1:0] : z_s0;
	end

	// ties go to z, then y
	always_comb begin
		sel_z = (az >= ax) && (az >= ay);
		sel_y = !sel_z && (ay >= ax);
		if (sel_z) begin
			major = az;
			if (z_s0[cmtx_pkg::DIR_W-1]) begin
				face = cmtx_pkg::FACE_NZ;
				sc   = {nx[cmtx_pkg::DIR_W], nx};
			end else begin
				face = cmtx_pkg::FACE_PZ;
				sc   = {xe[cmtx_pkg::DIR_W], xe};
			end
			tc = {ny[cmtx_pkg::DIR_W], ny};
		end else if (sel_y) begin
			major = ay;
			sc    = {xe[cmtx_pkg::DIR_W], xe};
			if (y_s0[cmtx_pkg::DIR_W-1]) begin
				face = cmtx_pkg::FACE_NY;
				tc   = {nz[cmtx_pkg::DIR_W], nz};
			end else begin
				face = cmtx_pkg::FACE_PY;
				tc   = {ze[cmtx_pkg::DIR_W], ze};
			end
		end else begin
			major = ax;
			if (x_s0[cmtx_pkg::DIR_W-1]) begin
				face = cmtx_pkg::FACE_NX;
				sc   = {ze[cmtx_pkg::DIR_W], ze};
			end else begin
				face = cmtx_pkg::FACE_PX;
				sc   = {nz[cmtx_pkg::DIR_W], nz};
			end
			tc = {ny[cmtx_pkg::DIR_W], ny};
		end
		sum_u = {2'b00, major} + sc;
		sum_v = {2'b00, major} + tc;
	end

	always_ff @(posedge clk) begin
		face_s1  <= face;
		zero_s1  <= (ax == '0) && (ay == '0) && (az == '0);
		major_s1 <= major;
		nu_s1    <= sum_u[cmtx_pkg::DIV_W-1:0];
		nv_s1    <= sum_v[cmtx_pkg::DIV_W-1:0];
	end

	// leading quotient bit: set only when the minor equals the major
	always_comb begin
		div   = {major_s1, 1'b0};
		q16_u = (nu_s1 == div);
		q16_v = (nv_s1 == div);
	end

	always_ff @(posedge clk) begin
		div_s2.div    <= div;
		div_s2.rem_u  <= q16_u ? '0 : nu_s1[cmtx_pkg::REM_W-1:0];
		div_s2.quo_u  <= {{(cmtx_pkg::QUO_W-1){1'b0}}, q16_u};
		div_s2.rem_v  <= q16_v ? '0 : nv_s1[cmtx_pkg::REM_W-1:0];
		div_s2.quo_v  <= {{(cmtx_pkg::QUO_W-1){1'b0}}, q16_v};
		side_s2.face  <= face_s1;
		side_s2.zero  <= zero_s1;
	end

	assign next_valid = valid_s2;
	assign next_div   = div_s2;
	assign next_side  = side_s2;
endmodule
`default_nettype wire

### rtl/cmtx_div_cell.sv
// one restoring divide step for both face coordinates
// depends on cmtx_pkg
`default_nettype none
module cmtx_div_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   prev_valid,
	input  cmtx_pkg::cmtx_div_t         prev_div,
	input  cmtx_pkg::cmtx_side_t        prev_side,
	output logic                        next_valid,
	output cmtx_pkg::cmtx_div_t         next_div,
	output cmtx_pkg::cmtx_side_t        next_side
);
	logic                         valid_q;
	cmtx_pkg::cmtx_div_t          div_q, step;
	cmtx_pkg::cmtx_side_t         side_q;
	logic [cmtx_pkg::DIV_W-1:0]   tu, tv, du, dv;
	logic                         ge_u, ge_v;

	always_comb begin
		tu   = {prev_div.rem_u, 1'b0};
		tv   = {prev_div.rem_v, 1'b0};
		ge_u = (tu >= prev_div.div);
		ge_v = (tv >= prev_div.div);
		du   = ge_u ? (tu - prev_div.div) : tu;
		dv   = ge_v ? (tv - prev_div.div) : tv;
		step.div   = prev_div.div;
		step.rem_u = du[cmtx_pkg::REM_W-1:0];
		step.rem_v = dv[cmtx_pkg::REM_W-1:0];
		step.quo_u = {prev_div.quo_u[cmtx_pkg::QUO_W-2:0], ge_u};
		step.quo_v = {prev_div.quo_v[cmtx_pkg::QUO_W-2:0], ge_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		div_q  <= step;
		side_q <= prev_side;
	end

	assign next_valid = valid_q;
	assign next_div   = div_q;
	assign next_side  = side_q;
endmodule
`default_nettype wire

### rtl/cmtx_back.sv
// back end: texel scaling, byte address, bounds check and status
// depends on cmtx_pkg
`default_nettype none
module cmtx_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   prev_valid,
	input  cmtx_pkg::cmtx_div_t         prev_div,
	input  cmtx_pkg::cmtx_side_t        prev_side,
	input  cmtx_pkg::cmtx_cfg_t         cfg,
	output logic                        res_valid,
	output cmtx_pkg::cmtx_res_t         res
);
	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic [27:0]                   px, py;
	logic [cmtx_pkg::TEX_W-1:0]    tx_s1, ty_s1, tx_s2, ty_s2, tx_s3, ty_s3;
	logic [2:0]                    face_s1, face_s2, face_s3;
	logic                          zero_s1, zero_s2, zero_s3;
	logic [30:0]                   pf_s2;
	logic [27:0]                   py_s2;
	logic [14:0]                   px_s2;
	logic [cmtx_pkg::ADDR_W-1:0]   addr_s3;
	logic [cmtx_pkg::ADDR_W:0]     last;
	logic [2:0]                    status;
	cmtx_pkg::cmtx_res_t           res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= prev_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// low 16 quotient bits: a coordinate of exactly one wraps to zero
	always_comb begin
		px = 28'(prev_div.quo_u[cmtx_pkg::UV_FRAC-1:0]) * 28'(cfg.w_m1)
			+ 28'(1 << (cmtx_pkg::UV_FRAC - 1));
		py = 28'(prev_div.quo_v[cmtx_pkg::UV_FRAC-1:0]) * 28'(cfg.h_m1)
			+ 28'(1 << (cmtx_pkg::UV_FRAC - 1));
	end

	always_ff @(posedge clk) begin
		tx_s1   <= px[27:cmtx_pkg::UV_FRAC];
		ty_s1   <= py[27:cmtx_pkg::UV_FRAC];
		face_s1 <= prev_side.face;
		zero_s1 <= prev_side.zero;
	end

	always_ff @(posedge clk) begin
		pf_s2   <= 31'(face_s1) * 31'(cfg.whn);
		py_s2   <= 28'(ty_s1) * 28'(cfg.wn);
		px_s2   <= 15'(tx_s1) * 15'(cfg.n);
		tx_s2   <= tx_s1;
		ty_s2   <= ty_s1;
		face_s2 <= face_s1;
		zero_s2 <= zero_s1;
	end

	always_ff @(posedge clk) begin
		addr_s3 <= 32'(pf_s2) + 32'(py_s2) + 32'(px_s2);
		tx_s3   <= tx_s2;
		ty_s3   <= ty_s2;
		face_s3 <= face_s2;
		zero_s3 <= zero_s2;
	end

	always_comb begin
		last = {1'b0, addr_s3} + 33'(cfg.n);
		if (!cfg.is_cube) begin
			status = cmtx_pkg::ST_NOT_CUBE;
		end else if (zero_s3) begin
			status = cmtx_pkg::ST_ZERO_DIR;
		end else if ({5'b0, face_s3} >= cfg.layers) begin
			status = cmtx_pkg::ST_FACE_OOR;
		end else if (!cfg.bytes_ok) begin
			status = cmtx_pkg::ST_BAD_BYTES;
		end else if (last > {1'b0, cfg.base}) begin
			status = cmtx_pkg::ST_OOB;
		end else begin
			status = cmtx_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (!cfg.is_cube || zero_s3) begin
			res_s4.face <= '0;
			res_s4.tx   <= '0;
			res_s4.ty   <= '0;
		end else begin
			res_s4.face <= face_s3;
			res_s4.tx   <= tx_s3;
			res_s4.ty   <= ty_s3;
		end
		res_s4.addr   <= (status == cmtx_pkg::ST_OK) ? addr_s3 : '0;
		res_s4.status <= status;
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;
endmodule
`default_nettype wire

### rtl/cmtx_fifo.sv
// result queue between the fixed-latency pipeline and the output port
// depends on cmtx_pkg
`default_nettype none
module cmtx_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  cmtx_pkg::cmtx_res_t  wr_data,
	input  wire logic            rd_en,
	output cmtx_pkg::cmtx_res_t  rd_data,
	output logic                 not_empty
);
	cmtx_pkg::cmtx_res_t             mem [cmtx_pkg::FIFO_DEPTH];
	logic [cmtx_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [cmtx_pkg::CREDIT_W-1:0]   count_q;

	function automatic logic [cmtx_pkg::CREDIT_W-1:0] CREDIT_ONE(input logic b);
		return {{(cmtx_pkg::CREDIT_W-1){1'b0}}, b};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CREDIT_ONE(wr_en) - CREDIT_ONE(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data   = mem[rd_ptr_q];
	assign not_empty = (count_q != '0);
endmodule
`default_nettype wire

### rtl/cube_map_texel_address.sv
// cube map texel address unit, top level: an input transfer runs through the pipeline to a queue write,
// and the result can then transfer from the queue; one lookup accepted per clock while credits remain,
// passing through the single-pass pipeline (3 front stages, 16 divide cells, 4 back stages)
// a 32-entry result queue with credit count lets input run while output stalls
// asynchronous active-low reset clears valid bits, credits and config to defaults
`default_nettype none
module cube_map_texel_address (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [cmtx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cmtx_pkg::CFG_DATA_W-1:0]   cfg_data,
	// direction input
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [cmtx_pkg::DIR_W-1:0]        dir_x,
	input  wire logic [cmtx_pkg::DIR_W-1:0]        dir_y,
	input  wire logic [cmtx_pkg::DIR_W-1:0]        dir_z,
	// result output
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [2:0]                             face,
	output logic [cmtx_pkg::TEX_W-1:0]             texel_x,
	output logic [cmtx_pkg::TEX_W-1:0]             texel_y,
	output logic [cmtx_pkg::ADDR_W-1:0]            byte_address,
	output logic [2:0]                             status
);
	// configuration registers
	logic                          is_cube_q;
	logic [cmtx_pkg::EXT_W-1:0]    face_w_q, face_h_q;
	logic [7:0]                    layers_q;
	logic [2:0]                    channels_q, chan_bytes_q;
	logic [cmtx_pkg::ADDR_W-1:0]   base_q;
	// derived config, registered in steps after a write: clamped extents, then row stride and area, then face stride
	logic [cmtx_pkg::EXT_W-1:0]    w_eff_q, h_eff_q, w_eff, h_eff;
	logic [cmtx_pkg::WN_W-1:0]     wn_q;
	logic [24:0]                   wh_q;
	logic [cmtx_pkg::WHN_W-1:0]    whn_q;
	cmtx_pkg::cmtx_cfg_t           cfg;

	logic                          in_xfer, out_xfer;
	logic [cmtx_pkg::CREDIT_W-1:0] credit_q;

	logic                          chain_valid [cmtx_pkg::DIV_CELLS+1];
	cmtx_pkg::cmtx_div_t           chain_div   [cmtx_pkg::DIV_CELLS+1];
	cmtx_pkg::cmtx_side_t          chain_side  [cmtx_pkg::DIV_CELLS+1];

	logic                          res_valid;
	cmtx_pkg::cmtx_res_t           res, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_cube_q    <= 1'b1;
			face_w_q     <= 13'd1;
			face_h_q     <= 13'd1;
			layers_q     <= 8'd6;
			channels_q   <= 3'd4;
			chan_bytes_q <= 3'd1;
			base_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmtx_pkg::CFG_IS_CUBE:    is_cube_q    <= cfg_data[0];
				cmtx_pkg::CFG_FACE_W:     face_w_q     <= cfg_data[cmtx_pkg::EXT_W-1:0];
				cmtx_pkg::CFG_FACE_H:     face_h_q     <= cfg_data[cmtx_pkg::EXT_W-1:0];
				cmtx_pkg::CFG_LAYERS:     layers_q     <= cfg_data[7:0];
				cmtx_pkg::CFG_CHANNELS:   channels_q   <= cfg_data[2:0];
				cmtx_pkg::CFG_CHAN_BYTES: chan_bytes_q <= cfg_data[2:0];
				cmtx_pkg::CFG_BASE_BYTES: base_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero extent acts as one, oversize clamps to the max extent
	always_comb begin
		if (face_w_q == '0) begin
			w_eff = 13'd1;
		end else if (face_w_q > 13'(cmtx_pkg::MAX_EXT)) begin
			w_eff = 13'(cmtx_pkg::MAX_EXT);
		end else begin
			w_eff = face_w_q;
		end
		if (face_h_q == '0) begin
			h_eff = 13'd1;
		end else if (face_h_q > 13'(cmtx_pkg::MAX_EXT)) begin
			h_eff = 13'(cmtx_pkg::MAX_EXT);
		end else begin
			h_eff = face_h_q;
		end
	end

	// row and face strides, one multiply per register
	always_ff @(posedge clk) begin
		w_eff_q <= w_eff;
		h_eff_q <= h_eff;
		wn_q    <= 16'(w_eff_q) * 16'(channels_q);
		wh_q    <= 25'(w_eff_q) * 25'(h_eff_q);
		whn_q   <= 28'(wh_q) * 28'(channels_q);
	end

	always_comb begin
		cfg.is_cube  = is_cube_q;
		cfg.w_m1     = 12'(w_eff_q - 13'd1);
		cfg.h_m1     = 12'(h_eff_q - 13'd1);
		cfg.wn       = wn_q;
		cfg.whn      = whn_q;
		cfg.n        = channels_q;
		cfg.bytes_ok = (chan_bytes_q == 3'd1);
		cfg.layers   = layers_q;
		cfg.base     = base_q;
	end

	// credits count items in flight plus queued results, so the queue never overflows
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign in_ready = (credit_q != cmtx_pkg::CREDIT_W'(cmtx_pkg::FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + {{(cmtx_pkg::CREDIT_W-1){1'b0}}, in_xfer}
				- {{(cmtx_pkg::CREDIT_W-1){1'b0}}, out_xfer};
		end
	end

	// face pick and divider setup
	cmtx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (in_xfer),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.dir_z      (dir_z),
		.next_valid (chain_valid[0]),
		.next_div   (chain_div[0]),
		.next_side  (chain_side[0])
	);

	// one quotient bit per cell, both coordinates side by side
	for (genvar i = 0; i < cmtx_pkg::DIV_CELLS; i++) begin : g_cell
		cmtx_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (chain_valid[i]),
			.prev_div   (chain_div[i]),
			.prev_side  (chain_side[i]),
			.next_valid (chain_valid[i+1]),
			.next_div   (chain_div[i+1]),
			.next_side  (chain_side[i+1])
		);
	end

	// texel scaling, address and status
	cmtx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (chain_valid[cmtx_pkg::DIV_CELLS]),
		.prev_div   (chain_div[cmtx_pkg::DIV_CELLS]),
		.prev_side  (chain_side[cmtx_pkg::DIV_CELLS]),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	cmtx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (res_valid),
		.wr_data   (res),
		.rd_en     (out_xfer),
		.rd_data   (head),
		.not_empty (out_valid)
	);

	assign face         = head.face;
	assign texel_x      = head.tx;
	assign texel_y      = head.ty;
	assign byte_address = head.addr;
	assign status       = head.status;
endmodule
`default_nettype wire

### rtl/cmtx_checker.sv
// port-level checks for the cube map texel address unit, bound to the top level
// depends on cmtx_pkg and cube_map_texel_address
`default_nettype none
module cmtx_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [2:0]                        face,
	input wire logic [cmtx_pkg::TEX_W-1:0]        texel_x,
	input wire logic [cmtx_pkg::TEX_W-1:0]        texel_y,
	input wire logic [cmtx_pkg::ADDR_W-1:0]       byte_address,
	input wire logic [2:0]                        status
);
	// a stalled result holds its address and status
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_address) && $stable(status))
		else $error("result changed while stalled");

	// address only on success
	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != cmtx_pkg::ST_OK) |-> byte_address == '0)
		else $error("address set on failed lookup");

	// no face or texel without a valid direction on a cube
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == cmtx_pkg::ST_NOT_CUBE || status == cmtx_pkg::ST_ZERO_DIR)
		|-> face == '0 && texel_x == '0 && texel_y == '0)
		else $error("fields set on not-cube or zero direction");

	// face and status codes in range whenever a result is valid
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> face <= cmtx_pkg::FACE_NZ && status <= cmtx_pkg::ST_ZERO_DIR)
		else $error("face or status code out of range");
endmodule

bind cube_map_texel_address cmtx_checker u_cmtx_checker (.*);
`default_nettype wire
